FILE: design/slbse_pkg.sv
`default_nettype none

package slbse_pkg;

  // Slot geometry of one LED refill.
  localparam int SLOTS_PER_LED = 24;
  localparam int SLOT_IDX_W    = $clog2(SLOTS_PER_LED);
  localparam int COLOR_W       = 8;
  localparam int TICKS_W       = 16;
  localparam int WORD_W        = 3 * COLOR_W;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ORDER     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH_TICKS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH_TICKS = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAUSE_SLOTS     = 2'd3;

  // Color order codes.
  localparam logic ORDER_RGB = 1'b0;
  localparam logic ORDER_GRB = 1'b1;

  // Register values after reset.
  localparam logic               RST_COLOR_ORDER     = ORDER_GRB;
  localparam logic [TICKS_W-1:0] RST_ONE_HIGH_TICKS  = 16'd67;
  localparam logic [TICKS_W-1:0] RST_ZERO_HIGH_TICKS = 16'd39;
  localparam logic [TICKS_W-1:0] RST_PAUSE_SLOTS     = 16'd237;

  // Configuration as seen by the slot logic.
  typedef struct packed {
    logic               color_order;
    logic [TICKS_W-1:0] one_high_ticks;
    logic [TICKS_W-1:0] zero_high_ticks;
    logic [TICKS_W-1:0] pause_slots;
  } cfg_t;

  // One bit slot on its way to the output register.
  typedef struct packed {
    logic [TICKS_W-1:0] high_ticks;
    logic               slot_last;
    logic               frame_done;
  } slot_t;

  // Sequencer status toward the top level.
  typedef struct packed {
    logic busy;
    logic advance;
    logic last;
  } seq_status_t;

endpackage

`default_nettype wire

FILE: design/slbse_if.sv
`default_nettype none

// Refill request channel.
interface slbse_req_if;
  logic                            valid;
  logic                            ready;
  logic                            frame_start;
  logic                            pixel_present;
  logic [slbse_pkg::COLOR_W-1:0]   red;
  logic [slbse_pkg::COLOR_W-1:0]   green;
  logic [slbse_pkg::COLOR_W-1:0]   blue;

  modport source (
    output valid, frame_start, pixel_present, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, frame_start, pixel_present, red, green, blue,
    output ready
  );
endinterface

// Bit slot channel.
interface slbse_slot_if;
  logic                            valid;
  logic                            ready;
  logic [slbse_pkg::TICKS_W-1:0]   high_ticks;
  logic                            slot_last;
  logic                            frame_done;

  modport source (
    output valid, high_ticks, slot_last, frame_done,
    input  ready
  );
  modport sink (
    input  valid, high_ticks, slot_last, frame_done,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/slbse_cfg.sv
`default_nettype none

module slbse_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wen,
  input  wire logic [slbse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [slbse_pkg::CFG_DATA_W-1:0]   cfg_data,
  output slbse_pkg::cfg_t                         cfg
);

  // Register file, written one register per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_order     <= slbse_pkg::RST_COLOR_ORDER;
      cfg.one_high_ticks  <= slbse_pkg::RST_ONE_HIGH_TICKS;
      cfg.zero_high_ticks <= slbse_pkg::RST_ZERO_HIGH_TICKS;
      cfg.pause_slots     <= slbse_pkg::RST_PAUSE_SLOTS;
    end else if (cfg_wen) begin
      case (cfg_index)
        slbse_pkg::REG_COLOR_ORDER:     cfg.color_order     <= cfg_data[0];
        slbse_pkg::REG_ONE_HIGH_TICKS:  cfg.one_high_ticks  <= cfg_data;
        slbse_pkg::REG_ZERO_HIGH_TICKS: cfg.zero_high_ticks <= cfg_data;
        slbse_pkg::REG_PAUSE_SLOTS:     cfg.pause_slots     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/slbse_seq.sv
`default_nettype none

module slbse_seq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire slbse_pkg::cfg_t       cfg,
  slbse_req_if.sink                  req,
  input  wire logic                  slot_take,
  output logic                       slot_valid,
  output slbse_pkg::slot_t           slot,
  output slbse_pkg::seq_status_t     status
);

  logic                                busy;
  logic                                px;
  logic [slbse_pkg::WORD_W-1:0]        word;
  logic [slbse_pkg::SLOT_IDX_W-1:0]    slot_idx;
  logic [slbse_pkg::TICKS_W-1:0]       pause_count;
  logic [slbse_pkg::TICKS_W-1:0]       pause_count_next;
  logic [slbse_pkg::TICKS_W-1:0]       pause_bumped;
  logic                                pause_open;
  logic                                last;
  logic                                advance;
  logic                                accept;
  logic [slbse_pkg::WORD_W-1:0]        load_word;

  localparam logic [slbse_pkg::SLOT_IDX_W-1:0] LAST_IDX =
    slbse_pkg::SLOT_IDX_W'(slbse_pkg::SLOTS_PER_LED - 1);

  // Handshake: a new request enters while the final slot of the current one leaves.
  assign last       = (slot_idx == LAST_IDX);
  assign advance    = busy && slot_take;
  assign req.ready  = !busy || (advance && last);
  assign accept     = req.valid && req.ready;
  assign slot_valid = busy;

  assign status.busy    = busy;
  assign status.advance = advance;
  assign status.last    = last;

  // Color word in transmit order, most significant bit goes first.
  assign load_word = (cfg.color_order == slbse_pkg::ORDER_GRB) ?
                     {req.green, req.red, req.blue} :
                     {req.red, req.green, req.blue};

  // Pause counting saturates at the configured pause length.
  assign pause_open   = (pause_count < cfg.pause_slots);
  assign pause_bumped = pause_open ? (pause_count + 1'b1) : pause_count;

  // Slot contents for the current position.
  always_comb begin
    slot.slot_last  = last;
    if (px) begin
      slot.high_ticks = word[slbse_pkg::WORD_W-1] ? cfg.one_high_ticks
                                                 : cfg.zero_high_ticks;
      slot.frame_done = 1'b0;
    end else begin
      slot.high_ticks = '0;
      slot.frame_done = last && (pause_bumped >= cfg.pause_slots);
    end
  end

  // Pause count: frame start clears after the outgoing slot has counted.
  always_comb begin
    pause_count_next = pause_count;
    if (advance && !px) begin
      pause_count_next = pause_bumped;
    end
    if (accept && req.frame_start) begin
      pause_count_next = '0;
    end
  end

  // Request register and slot position.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      slot_idx    <= '0;
      pause_count <= '0;
    end else begin
      pause_count <= pause_count_next;
      if (accept) begin
        busy     <= 1'b1;
        slot_idx <= '0;
      end else if (advance) begin
        if (last) begin
          busy <= 1'b0;
        end
        slot_idx <= slot_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px   <= req.pixel_present;
      word <= load_word;
    end else if (advance) begin
      word <= {word[slbse_pkg::WORD_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

FILE: design/slbse_out.sv
`default_nettype none

module slbse_out (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            slot_valid,
  input  wire slbse_pkg::slot_t slot,
  output logic                 slot_take,
  slbse_slot_if.source         out
);

  slbse_pkg::slot_t held;

  // The register takes a slot when it is empty or being emptied.
  assign slot_take = !out.valid || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (slot_take) begin
      out.valid <= slot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_take && slot_valid) begin
      held <= slot;
    end
  end

  assign out.high_ticks = held.high_ticks;
  assign out.slot_last  = held.slot_last;
  assign out.frame_done = held.frame_done;

endmodule

`default_nettype wire

FILE: design/serial_led_bit_slot_encoder_top.sv
// Channel     Direction  Payload
// pixel_in    in         frame_start, pixel_present, red, green, blue
// slot_out    out        high_ticks, slot_last, frame_done
// cfg_*       in         register index and write data, no read-back
//
// Every request expands into 24 slots, one slot per cycle while the output
// register is not stalled; the next request is taken in the cycle the final
// slot moves to the output register.
// Reset is synchronous and clears the registers to their defaults, the
// pause count and all valid flags. A stalled output holds its slot and
// stops the sequencer until the transaction completes.
`default_nettype none

module serial_led_bit_slot_encoder_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wen,
  input  wire logic [slbse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [slbse_pkg::CFG_DATA_W-1:0]   cfg_data,
  slbse_req_if.sink                               pixel_in,
  slbse_slot_if.source                            slot_out
);

  slbse_pkg::cfg_t         cfg;
  slbse_pkg::slot_t        slot;
  slbse_pkg::seq_status_t  status;
  logic                    slot_valid;
  logic                    slot_take;

  // Configuration registers.
  slbse_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Request register and slot sequencer.
  slbse_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req        (pixel_in),
    .slot_take  (slot_take),
    .slot_valid (slot_valid),
    .slot       (slot),
    .status     (status)
  );

  // Output register.
  slbse_out u_out (
    .clk        (clk),
    .rst        (rst),
    .slot_valid (slot_valid),
    .slot       (slot),
    .slot_take  (slot_take),
    .out        (slot_out)
  );

  // A request is only taken into a busy sequencer as its final slot leaves.
  assert property (@(posedge clk) disable iff (rst)
    (pixel_in.valid && pixel_in.ready && status.busy) |-> (status.advance && status.last))
    else $error("request accepted while slots still pending");

  // Frame done only ever rides on the final slot of a refill.
  assert property (@(posedge clk) disable iff (rst)
    (slot_out.valid && slot_out.frame_done) |-> slot_out.slot_last)
    else $error("frame_done on a slot that is not the last");

  // After the final slot leaves with no new request, the sequencer goes idle.
  assert property (@(posedge clk) disable iff (rst)
    (status.advance && status.last && !(pixel_in.valid && pixel_in.ready))
      |=> !status.busy)
    else $error("sequencer stayed busy after final slot");

  // An emptied output register is refilled only when the sequencer is busy.
  assert property (@(posedge clk) disable iff (rst)
    (!status.busy && slot_take) |=> !slot_out.valid)
    else $error("output valid without a slot from the sequencer");

endmodule

`default_nettype wire
